// File: rtl/core/ntga_pkg.sv
// Shared types, constants and helper functions for the track association core.
package ntga_pkg;

  localparam int MAX_TRACKS = 64;
  localparam int IDX_W      = $clog2(MAX_TRACKS);
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
  localparam int COORD_W    = 20;
  localparam int MAG_W      = COORD_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int D2_W       = SQ_W + 2;
  localparam int GATE_W     = 19;
  localparam int GATE2_W    = 2 * GATE_W;
  localparam int LEN_W      = 16;
  localparam int ID_W       = 6;

  localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(1024);
  localparam logic [LEN_W-1:0]  COUNT_MAX  = {LEN_W{1'b1}};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [D2_W-1:0]           dist_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [LEN_W-1:0]          len_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    len_t   count;
  } track_t;

  typedef struct packed {
    logic valid;
    idx_t id;
    len_t count;
  } dist_tag_t;

  function automatic mag_t abs_diff(coord_t a, coord_t b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return m[MAG_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] to_track_id(idx_t idx);
    logic [IDX_W+ID_W-1:0] wide;
    wide = {{ID_W{1'b0}}, idx};
    return wide[ID_W-1:0];
  endfunction

endpackage

// File: rtl/core/ntga_track_mem.sv
// Track table memory with one write port and one registered read port.
module ntga_track_mem
  import ntga_pkg::*;
(
  input  logic   clk,
  input  logic   wr_en,
  input  idx_t   wr_addr,
  input  track_t wr_data,
  input  logic   rd_en,
  input  idx_t   rd_addr,
  output track_t rd_data
);

  track_t mem [MAX_TRACKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/ntga_dist_unit.sv
// Pipelined squared distance unit shared by all stored tracks.
module ntga_dist_unit
  import ntga_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dist_tag_t in_tag,
  input  coord_t    px,
  input  coord_t    py,
  input  coord_t    pz,
  input  coord_t    tx,
  input  coord_t    ty,
  input  coord_t    tz,
  output dist_tag_t out_tag,
  output dist_t     d2,
  output logic      busy
);

  dist_tag_t tag1;
  dist_tag_t tag2;
  mag_t mx;
  mag_t my;
  mag_t mz;
  logic [SQ_W-1:0] sx;
  logic [SQ_W-1:0] sy;
  logic [SQ_W-1:0] sz;

  assign busy = tag1.valid | tag2.valid | out_tag.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid    <= 1'b0;
      tag2.valid    <= 1'b0;
      out_tag.valid <= 1'b0;
    end else begin
      tag1.valid    <= in_tag.valid;
      tag2.valid    <= tag1.valid;
      out_tag.valid <= tag2.valid;
    end
    tag1.id       <= in_tag.id;
    tag1.count    <= in_tag.count;
    tag2.id       <= tag1.id;
    tag2.count    <= tag1.count;
    out_tag.id    <= tag2.id;
    out_tag.count <= tag2.count;
    mx <= abs_diff(px, tx);
    my <= abs_diff(py, ty);
    mz <= abs_diff(pz, tz);
    sx <= SQ_W'(mx) * SQ_W'(mx);
    sy <= SQ_W'(my) * SQ_W'(my);
    sz <= SQ_W'(mz) * SQ_W'(mz);
    d2 <= D2_W'(sx) + D2_W'(sy) + D2_W'(sz);
  end

endmodule

// File: rtl/core/nearest_track_gate_association_core.sv
// Top level of the nearest track gate association core.
// Each point transaction is matched against every stored track, one track per clock,
// through a single distance pipeline fed from the one read port of the track table.
// From acceptance of a point until its result is written the point input is stalled,
// while a finished result may wait in its output register. The gate register is
// written only while no point is in work; the memory needs no clearing after reset
// because only tracks already opened are ever read.
module nearest_track_gate_association_core
  import ntga_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              gate_valid,
  output logic              gate_ready,
  input  logic [GATE_W-1:0] gate_distance,
  input  logic              point_valid,
  output logic              point_stall,
  input  coord_t            point_x,
  input  coord_t            point_y,
  input  coord_t            point_z,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [ID_W-1:0]   track_id,
  output logic              opened_new,
  output logic              dropped,
  output len_t              track_length
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_WRITE} state_t;

  state_t state;
  logic [GATE_W-1:0]  gate;
  logic [GATE2_W-1:0] gate2;
  coord_t px;
  coord_t py;
  coord_t pz;
  logic [CNT_W-1:0] tracks_in_use;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] rd_cnt_next;
  logic rd_v;
  idx_t rd_id;
  dist_t best;
  idx_t  best_id;
  len_t  best_cnt;
  logic  have;

  track_t    rd_data;
  track_t    wr_data;
  logic      wr_en;
  idx_t      wr_addr;
  dist_tag_t dist_in;
  dist_tag_t dist_out;
  dist_t     d2;
  logic      dist_busy;

  logic accept;
  logic out_free;
  logic match;
  logic full;
  len_t cnt_new;

  assign accept      = point_valid && !point_stall;
  assign point_stall = (state != S_IDLE);
  assign gate_ready  = (state == S_IDLE);
  assign out_free    = !result_valid || !result_stall;
  assign rd_cnt_next = rd_cnt + CNT_W'(1);

  assign match   = have && (best < D2_W'(gate2));
  assign full    = (tracks_in_use == CNT_W'(MAX_TRACKS));
  assign cnt_new = match ? ((best_cnt == COUNT_MAX) ? best_cnt : best_cnt + LEN_W'(1))
                         : LEN_W'(1);
  assign wr_addr = match ? best_id : tracks_in_use[IDX_W-1:0];
  assign wr_en   = (state == S_WRITE) && out_free && (match || !full);
  assign wr_data = '{x: px, y: py, z: pz, count: cnt_new};

  assign dist_in = '{valid: rd_v, id: rd_id, count: rd_data.count};

  ntga_track_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (state == S_SCAN),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  ntga_dist_unit u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (dist_in),
    .px      (px),
    .py      (py),
    .pz      (pz),
    .tx      (rd_data.x),
    .ty      (rd_data.y),
    .tz      (rd_data.z),
    .out_tag (dist_out),
    .d2      (d2),
    .busy    (dist_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      gate          <= GATE_RESET;
      tracks_in_use <= '0;
      rd_cnt        <= '0;
      rd_v          <= 1'b0;
      have          <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_WRITE)) begin
        result_valid <= 1'b0;
      end
      if (gate_valid && gate_ready) begin
        gate <= gate_distance;
      end
      rd_v  <= (state == S_SCAN);
      rd_id <= rd_cnt[IDX_W-1:0];
      if (dist_out.valid && (!have || d2 < best)) begin
        have     <= 1'b1;
        best     <= d2;
        best_id  <= dist_out.id;
        best_cnt <= dist_out.count;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            px     <= point_x;
            py     <= point_y;
            pz     <= point_z;
            gate2  <= GATE2_W'(gate) * GATE2_W'(gate);
            have   <= 1'b0;
            rd_cnt <= '0;
            state  <= (tracks_in_use == '0) ? S_WRITE : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_cnt <= rd_cnt_next;
          if (rd_cnt_next == tracks_in_use) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !dist_busy) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
            if (match) begin
              track_id     <= to_track_id(best_id);
              opened_new   <= 1'b0;
              dropped      <= 1'b0;
              track_length <= cnt_new;
            end else if (!full) begin
              track_id      <= to_track_id(tracks_in_use[IDX_W-1:0]);
              opened_new    <= 1'b1;
              dropped       <= 1'b0;
              track_length  <= cnt_new;
              tracks_in_use <= tracks_in_use + CNT_W'(1);
            end else begin
              track_id     <= '0;
              opened_new   <= 1'b0;
              dropped      <= 1'b1;
              track_length <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
